// ===== hw/rtl/sove_pkg.sv =====
// ----------------------------------------------------------------------------
// sove_pkg
// Shared types, constants and helper functions of the SML OBIS value
// extractor: configuration record, front-to-back beat, result beat.
// ----------------------------------------------------------------------------
package sove_pkg;

   // Longest ID code that can be matched, in bytes.
   localparam int CODE_BYTES = 8;
   localparam int WIN_W      = 8 * CODE_BYTES;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_CODE_BYTES   = 2'd0;
   localparam logic [1:0] CSR_CODE_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_VALUE_OFFSET = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [63:0] CODE_BYTES_RST   = 64'd0;
   localparam logic [3:0]  CODE_LENGTH_RST  = 4'd8;
   localparam logic [7:0]  VALUE_OFFSET_RST = 8'd15;

   // Kind of byte handed from the front to the back.
   typedef enum logic [1:0] {
      EV_SKIP,   // still searching, no match yet
      EV_HIT,    // this byte completes the ID code
      EV_DATA    // byte after the match
   } ev_kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK,
      ST_NOT_FOUND,
      ST_BAD_LENGTH,
      ST_TRUNCATED
   } status_type;

   // What the matched code bytes alone already settle.
   typedef enum logic [1:0] {
      PLAN_NONE,   // type-length byte lies after the code
      PLAN_BAD,    // type-length byte inside the code, bad length
      PLAN_DONE,   // whole value inside the code
      PLAN_OPEN    // value starts inside the code, continues after it
   } plan_kind_type;

   typedef struct packed {
      logic [63:0] code_bytes;
      logic [3:0]  code_length;
      logic [7:0]  value_offset;
   } cfg_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  data;
      logic        last;
   } event_type;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
   } result_type;

   // Code length clamped to 1..CODE_BYTES.
   function automatic logic [3:0] eff_length(input logic [3:0] len);
      logic [3:0] l;
      l = len;
      if (l == 4'd0) begin
         l = 4'd1;
      end
      if (l > 4'(CODE_BYTES)) begin
         l = 4'(CODE_BYTES);
      end
      return l;
   endfunction

   // Value offset with zero taken as one.
   function automatic logic [7:0] eff_offset(input logic [7:0] off);
      return (off == 8'd0) ? 8'd1 : off;
   endfunction

endpackage

// ===== hw/rtl/sove_front.sv =====
// ----------------------------------------------------------------------------
// sove_front
// Search side: keeps a window of the latest payload bytes, compares it with
// the configured ID code and tags every accepted byte for the back part.
// ----------------------------------------------------------------------------
module sove_front (
   input  logic                clock,
   input  logic                reset,
   input  sove_pkg::cfg_type   cfg,
   input  logic                accept,
   input  logic [7:0]          payload_byte,
   input  logic                last_byte,
   output sove_pkg::event_type ev
);

   logic [sove_pkg::WIN_W-1:0] win_ff;
   logic [sove_pkg::WIN_W-1:0] win_in;
   logic [3:0]                 fill_ff;
   logic [3:0]                 fill_in;
   logic                       matched_ff;
   logic                       matched_in;
   logic [3:0]                 len;
   logic [6:0]                 drop;
   logic [sove_pkg::WIN_W-1:0] code_top;
   logic [sove_pkg::WIN_W-1:0] mask;
   logic                       hit;

   // Window compare: the newest len bytes against the first len code bytes.
   always_comb begin
      len      = sove_pkg::eff_length(cfg.code_length);
      drop     = 7'(sove_pkg::WIN_W) - {len, 3'b000};
      win_in   = {win_ff[sove_pkg::WIN_W-9:0], payload_byte};
      fill_in  = (fill_ff == 4'(sove_pkg::CODE_BYTES)) ? fill_ff : fill_ff + 4'd1;
      code_top = cfg.code_bytes >> drop;
      mask     = {sove_pkg::WIN_W{1'b1}} >> drop;
      hit      = !matched_ff && (fill_in >= len) && (((win_in ^ code_top) & mask) == '0);
   end

   // Tag the byte for the back part.
   always_comb begin
      ev.data = payload_byte;
      ev.last = last_byte;
      if (matched_ff) begin
         ev.kind = sove_pkg::EV_DATA;
      end else if (hit) begin
         ev.kind = sove_pkg::EV_HIT;
      end else begin
         ev.kind = sove_pkg::EV_SKIP;
      end
   end

   // Search state; a final byte starts the next payload from scratch.
   always_comb begin
      matched_in = matched_ff;
      if (accept) begin
         if (last_byte) begin
            matched_in = 1'b0;
         end else if (hit) begin
            matched_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         matched_ff <= 1'b0;
      end else begin
         matched_ff <= matched_in;
         if (accept) begin
            if (last_byte) begin
               fill_ff <= '0;
            end else if (!matched_ff) begin
               fill_ff <= fill_in;
            end
         end
      end
   end

   // Window bytes only count once the fill covers them.
   always_ff @(posedge clock) begin
      if (accept && !matched_ff) begin
         win_ff <= win_in;
      end
   end

endmodule

// ===== hw/rtl/sove_evq.sv =====
// ----------------------------------------------------------------------------
// sove_evq
// Two-entry queue of tagged bytes between the search side and the decode
// side, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sove_evq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sove_pkg::event_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output sove_pkg::event_type head
);

   sove_pkg::event_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                rd_ptr_ff;
   logic [1:0]          count_ff;
   logic [1:0]          count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   // Occupancy follows the push and pop beats.
   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("evq: push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("evq: pop from an empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("evq: occupancy out of range");

endmodule

// ===== hw/rtl/sove_back.sv =====
// ----------------------------------------------------------------------------
// sove_back
// Decode side: follows the byte index after the match, reads the
// type-length byte, gathers the value and queues one result per payload.
// ----------------------------------------------------------------------------
module sove_back (
   input  logic                clock,
   input  logic                reset,
   input  sove_pkg::cfg_type   cfg,
   input  logic                ev_empty,
   input  sove_pkg::event_type ev_head,
   output logic                ev_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [31:0]         rsp_value,
   output logic [1:0]          rsp_status
);

   // Configuration derived values, registered.
   sove_pkg::plan_kind_type plan_kind_ff;
   sove_pkg::plan_kind_type plan_kind_in;
   logic [31:0]             plan_value_ff;
   logic [31:0]             plan_value_in;
   logic [3:0]              plan_vlen_ff;
   logic [3:0]              plan_vlen_in;
   logic [7:0]              off_ff;
   logic [7:0]              off_in;
   logic [3:0]              len_ff;
   logic [3:0]              len_in;

   // Plan helpers.
   logic [7:0]  p_tl_idx;
   logic [7:0]  p_tl_byte;
   logic [3:0]  p_nib;
   logic [3:0]  p_vlen;
   logic        p_good;
   logic [8:0]  p_end;
   logic        p_done;
   logic [3:0]  p_nbytes;
   logic [63:0] p_shifted;
   logic [63:0] p_picked;

   // Decode state.
   logic        matched_ff;
   logic        matched_in;
   logic [8:0]  bsm_ff;
   logic [8:0]  bsm_in;
   logic [3:0]  vlen_ff;
   logic [3:0]  vlen_in;
   logic [31:0] acc_ff;
   logic [31:0] acc_in;
   logic        reported_ff;
   logic        reported_in;

   // Visit helpers.
   logic [8:0]  off9;
   logic [8:0]  val_end;
   logic        go;
   logic        emit;
   sove_pkg::result_type emit_res;

   // Result queue.
   sove_pkg::result_type rq_ff [2];
   logic                 rq_wr_ptr_ff;
   logic                 rq_rd_ptr_ff;
   logic [1:0]           rq_count_ff;
   logic [1:0]           rq_count_in;
   logic                 rq_push;
   logic                 rq_pop;
   logic                 room;

   // What a match settles from the code bytes alone, given the registers.
   always_comb begin
      off_in    = sove_pkg::eff_offset(cfg.value_offset);
      len_in    = sove_pkg::eff_length(cfg.code_length);
      p_tl_idx  = off_in - 8'd1;
      p_tl_byte = 8'(cfg.code_bytes >> (7'd56 - {1'b0, p_tl_idx[2:0], 3'b000}));
      p_nib     = p_tl_byte[3:0];
      p_good    = (p_nib >= 4'd2) && (p_nib <= 4'd9);
      p_vlen    = p_nib - 4'd1;
      p_end     = {1'b0, off_in} + {5'd0, p_vlen};
      p_done    = p_end <= {5'd0, len_in};
      if (p_done) begin
         p_nbytes = p_vlen;
      end else if ({4'd0, len_in} > off_in) begin
         p_nbytes = len_in - off_in[3:0];
      end else begin
         p_nbytes = 4'd0;
      end
      p_shifted = cfg.code_bytes << {off_in[3:0], 3'b000};
      p_picked  = p_shifted >> (7'd64 - {p_nbytes, 3'b000});

      plan_vlen_in  = p_vlen;
      plan_value_in = p_picked[31:0];
      if (p_done && (p_vlen == 4'd1)) begin
         plan_value_in = {{24{p_picked[7]}}, p_picked[7:0]};
      end

      if (p_tl_idx >= {4'd0, len_in}) begin
         plan_kind_in = sove_pkg::PLAN_NONE;
      end else if (!p_good) begin
         plan_kind_in = sove_pkg::PLAN_BAD;
      end else if (p_done) begin
         plan_kind_in = sove_pkg::PLAN_DONE;
      end else begin
         plan_kind_in = sove_pkg::PLAN_OPEN;
      end
   end

   always_ff @(posedge clock) begin
      plan_kind_ff  <= plan_kind_in;
      plan_value_ff <= plan_value_in;
      plan_vlen_ff  <= plan_vlen_in;
      off_ff        <= off_in;
      len_ff        <= len_in;
   end

   // A beat is taken when the result queue can hold what it may produce.
   always_comb begin
      rq_pop = rsp_pop && (rq_count_ff != 2'd0);
      room   = (rq_count_ff != 2'd2) || rq_pop;
      go     = !ev_empty && room;
      ev_pop = go;
   end

   // Per-byte decode step.
   always_comb begin
      off9        = {1'b0, off_ff};
      val_end     = off9 + {5'd0, vlen_ff};
      matched_in  = matched_ff;
      bsm_in      = bsm_ff;
      vlen_in     = vlen_ff;
      acc_in      = acc_ff;
      reported_in = reported_ff;
      emit        = 1'b0;
      emit_res    = '{value: 32'd0, status: sove_pkg::ST_OK};

      if (go) begin
         if (!reported_ff) begin
            unique case (ev_head.kind)
               sove_pkg::EV_SKIP: begin
               end
               sove_pkg::EV_HIT: begin
                  matched_in = 1'b1;
                  bsm_in     = {5'd0, len_ff};
                  unique case (plan_kind_ff)
                     sove_pkg::PLAN_NONE: begin
                     end
                     sove_pkg::PLAN_BAD: begin
                        emit            = 1'b1;
                        emit_res.status = sove_pkg::ST_BAD_LENGTH;
                     end
                     sove_pkg::PLAN_DONE: begin
                        emit           = 1'b1;
                        emit_res.value = plan_value_ff;
                     end
                     sove_pkg::PLAN_OPEN: begin
                        vlen_in = plan_vlen_ff;
                        acc_in  = plan_value_ff;
                     end
                     default: begin
                     end
                  endcase
               end
               sove_pkg::EV_DATA: begin
                  if (bsm_ff == off9 - 9'd1) begin
                     // Type-length byte.
                     if ((ev_head.data[3:0] >= 4'd2) && (ev_head.data[3:0] <= 4'd9)) begin
                        vlen_in = ev_head.data[3:0] - 4'd1;
                        acc_in  = 32'd0;
                     end else begin
                        emit            = 1'b1;
                        emit_res.status = sove_pkg::ST_BAD_LENGTH;
                     end
                  end else if ((vlen_ff != 4'd0) && (bsm_ff >= off9) && (bsm_ff < val_end)) begin
                     // Value byte, big-endian.
                     acc_in = {acc_ff[23:0], ev_head.data};
                     if (bsm_ff == val_end - 9'd1) begin
                        emit = 1'b1;
                        if (vlen_ff == 4'd1) begin
                           emit_res.value = {{24{ev_head.data[7]}}, ev_head.data};
                        end else begin
                           emit_res.value = acc_in;
                        end
                     end
                  end
                  if (bsm_ff != 9'h1FF) begin
                     bsm_in = bsm_ff + 9'd1;
                  end
               end
               default: begin
               end
            endcase
         end

         reported_in = reported_ff || emit;

         // End of payload: report what is missing, then start over.
         if (ev_head.last) begin
            if (!reported_in) begin
               emit            = 1'b1;
               emit_res.status = matched_in ? sove_pkg::ST_TRUNCATED : sove_pkg::ST_NOT_FOUND;
            end
            matched_in  = 1'b0;
            bsm_in      = '0;
            vlen_in     = '0;
            acc_in      = '0;
            reported_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matched_ff  <= 1'b0;
         bsm_ff      <= '0;
         vlen_ff     <= '0;
         acc_ff      <= '0;
         reported_ff <= 1'b0;
      end else begin
         matched_ff  <= matched_in;
         bsm_ff      <= bsm_in;
         vlen_ff     <= vlen_in;
         acc_ff      <= acc_in;
         reported_ff <= reported_in;
      end
   end

   // Result queue toward the consumer.
   always_comb begin
      rq_push     = go && emit;
      rq_count_in = rq_count_ff + {1'b0, rq_push} - {1'b0, rq_pop};
      rsp_empty   = (rq_count_ff == 2'd0);
      rsp_value   = rq_ff[rq_rd_ptr_ff].value;
      rsp_status  = rq_ff[rq_rd_ptr_ff].status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ptr_ff <= 1'b0;
         rq_rd_ptr_ff <= 1'b0;
         rq_count_ff  <= '0;
      end else begin
         rq_count_ff <= rq_count_in;
         if (rq_push) begin
            rq_wr_ptr_ff <= !rq_wr_ptr_ff;
         end
         if (rq_pop) begin
            rq_rd_ptr_ff <= !rq_rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ptr_ff] <= emit_res;
      end
   end

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (go && !ev_head.last && emit) |=> reported_ff)
      else $error("back: result given without marking the payload reported");

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (go && reported_ff && !ev_head.last) |-> !emit)
      else $error("back: second result for one payload");

   a_len_after_match: assert property (@(posedge clock) disable iff (reset)
      (vlen_ff != 4'd0) |-> matched_ff)
      else $error("back: value length set before any match");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (go && ev_head.last) |=> (!matched_ff && !reported_ff && (vlen_ff == 4'd0)))
      else $error("back: state not cleared after the final byte");

   a_rq_range: assert property (@(posedge clock) disable iff (reset)
      rq_count_ff != 2'd3)
      else $error("back: result queue occupancy out of range");

endmodule

// ===== hw/rtl/sml_obis_value_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// sml_obis_value_extractor_unit
// Extracts one numeric value from an SML meter payload, located by its ID
// code, and reports it with a status once per payload.
//
//   Channel   Direction  Handshake          Beat
//   req_      in         push / full        payload_byte, last_byte
//   rsp_      out        empty / pop        value, status
//   csr_      in         wr_en (no wait)    index, wr_data
//
// One payload byte is taken per cycle while req_full is low; the window compare
// and the shift-accumulate step each sit in their own stage.
// A result passes the event queue and the result queue before it reaches rsp_.
// A two-entry queue separates search from decode, a second one holds results;
// full rises only when results are not popped and both queues fill up.
// Synchronous reset clears all control state; the registers take their
// reset values.
// ----------------------------------------------------------------------------
module sml_obis_value_extractor_unit (
   input  logic        clock,
   input  logic        reset,
   // Input beats.
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_last_byte,
   // Result beats.
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_value,
   output logic [1:0]  rsp_status,
   // Configuration writes.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   sove_pkg::cfg_type   cfg_ff;
   sove_pkg::cfg_type   cfg_in;
   sove_pkg::event_type front_ev;
   sove_pkg::event_type evq_head;
   logic                req_accept;
   logic                evq_empty;
   logic                evq_pop;

   assign req_accept = req_push && !req_full;

   // Configuration register write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sove_pkg::CSR_CODE_BYTES:   cfg_in.code_bytes   = csr_wr_data;
            sove_pkg::CSR_CODE_LENGTH:  cfg_in.code_length  = csr_wr_data[3:0];
            sove_pkg::CSR_VALUE_OFFSET: cfg_in.value_offset = csr_wr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_bytes   <= sove_pkg::CODE_BYTES_RST;
         cfg_ff.code_length  <= sove_pkg::CODE_LENGTH_RST;
         cfg_ff.value_offset <= sove_pkg::VALUE_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Search side.
   sove_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .accept       (req_accept),
      .payload_byte (req_payload_byte),
      .last_byte    (req_last_byte),
      .ev           (front_ev)
   );

   // Queue between search and decode.
   sove_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_ev),
      .full      (req_full),
      .pop       (evq_pop),
      .empty     (evq_empty),
      .head      (evq_head)
   );

   // Decode side with result queue.
   sove_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .ev_empty   (evq_empty),
      .ev_head    (evq_head),
      .ev_pop     (evq_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule
